// ===== src/ppg_prd_pkg.sv =====
// ============================================================================
// ppg_prd_pkg
// Shared types and constants of the optical pulse rate detector: sequencer
// states, direction codes, register addresses and the divider request bundle.
// ============================================================================
package ppg_prd_pkg;

	// Register byte addresses on the configuration port.
	localparam logic [3:0] ADDR_TICKS_PER_MINUTE = 4'h0;
	localparam logic [3:0] ADDR_IDLE_TICKS_LIMIT = 4'h4;
	localparam logic [3:0] ADDR_RATE_GATE        = 4'h8;

	// Register reset values.
	localparam logic [15:0] TPM_RESET  = 16'd3000;
	localparam logic [15:0] IDLE_RESET = 16'd200;
	localparam logic [7:0]  GATE_RESET = 8'd15;
	localparam logic [15:0] HELD_RESET = 16'd75;

	// Turning-point trackers restart from these values after every peak.
	localparam logic [31:0] RMAX_RESET = 32'hFFFF_F000;
	localparam logic [31:0] RMIN_RESET = 32'd4095;

	// Stream payload widths.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		DIR_NONE = 2'b00,
		DIR_RISE = 2'b01,
		DIR_FALL = 2'b10
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT1,
		ST_FILT2,
		ST_AVG_PUSH,
		ST_AVG_GO,
		ST_THR_GO,
		ST_TURN,
		ST_PEAK,
		ST_INT_GO,
		ST_RATE_GO,
		ST_DIV_WAIT,
		ST_GATE,
		ST_DONE
	} state_t;

	// Request to the shared serial divider.
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	// Response of the shared serial divider.
	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/ppg_prd_div.sv =====
// ============================================================================
// ppg_prd_div
// Unsigned restoring divider, one quotient bit per cycle. A request starts a
// run; done pulses for one cycle when the quotient is ready, and the
// quotient then holds until the next request.
// ============================================================================
module ppg_prd_div
	import ppg_prd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/ppg_pulse_rate_detector_top.sv =====
// ============================================================================
// ppg_pulse_rate_detector_top
// Pulse rate from an optical pulse sensor: shift-only scaling and band-pass,
// moving average, turning-point peak detection and a gated rate estimate.
// ============================================================================
// Usage:
// One sample request enters on the s_ stream (raw sample and tick stamp) and
// produces exactly one result on the m_ stream (filtered value, rate and a
// peak flag in m_tuser). The block works on one sample at a time under a
// small sequencer; s_tready is high only while it is idle.
// A sample goes through nine filter and peak steps, then the rate division on
// the shared serial divider, a gate step and a final step with the default
// power-of-two window and history sizes. Without a positive mean interval
// there is no division. When a size is not a power of two, its rounded mean
// also goes through the divider, for up to three such means per sample.
// The result sits in an output register, so a new sample is taken while an
// earlier result still waits; if the receiver stalls, the finished sample
// waits in its last step until the output register frees up.
// Reset clears all filter, window and history state, restores the register
// defaults and the held rate of 75, and leaves both streams empty.
// Registers are written through the APB port; the user must do so only
// while the block is idle, since the block itself does not enforce it.
// ============================================================================
module ppg_pulse_rate_detector_top
	import ppg_prd_pkg::*;
#(
	parameter int AVERAGE_TAPS  = 8,
	parameter int HISTORY_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Sample stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // raw_sample[11:0], tick_count[43:12], zero pad
	// Result stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // filtered_value[31:0], heart_rate[47:32]
	output logic                 m_tuser,   // peak_found
	// Configuration port.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int          AVG_LOG   = $clog2(AVERAGE_TAPS);
	localparam int          HIST_LOG  = $clog2(HISTORY_DEPTH);
	localparam bit          AVG_POW2  = (AVERAGE_TAPS & (AVERAGE_TAPS - 1)) == 0;
	localparam bit          HIST_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;
	localparam logic [31:0] AVG_HALF  = 32'(AVERAGE_TAPS / 2);
	localparam logic [31:0] HIST_HALF = 32'(HISTORY_DEPTH / 2);

	// Configuration registers.
	logic [15:0] tpm_q;
	logic [15:0] idle_q;
	logic [7:0]  gate_q;

	// Sequencer.
	state_t state_q, state_d;
	state_t ret_q;

	// Filter and detection state.
	logic [31:0] sh0_q, sh1_q;
	logic [31:0] fh0_q, fh1_q;
	logic [31:0] win_q  [AVERAGE_TAPS];
	logic [31:0] ivl_q  [HISTORY_DEPTH];
	logic [31:0] swg_q  [HISTORY_DEPTH];
	logic [31:0] avg_sum_q;
	logic [31:0] ivl_sum_q;
	logic [31:0] swg_sum_q;
	logic [31:0] prev_f_q;
	dir_t        prev_dir_q;
	logic [31:0] rmax_q;
	logic [31:0] rmin_q;
	logic [31:0] lpt_q;
	logic [15:0] held_q;

	// Per-sample working registers.
	logic [11:0] raw_q;
	logic [31:0] tick_q;
	logic [31:0] acc_q;
	logic [31:0] res_q;
	logic [31:0] f_q;
	logic        neg_q;
	logic        peak_q;

	// Output register.
	logic        m_tvalid_q;
	logic [31:0] out_f_q;
	logic [15:0] out_rate_q;
	logic        out_peak_q;

	// Divider link.
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Combinational helpers.
	logic [31:0] x_val;
	logic [31:0] y_val;
	logic        sel_avg;
	logic        mean_use_div;
	logic [31:0] mean_s;
	logic [31:0] mean_u;
	logic [31:0] mean_q;
	logic [31:0] mean_pow2;
	logic        f_rise, f_fall;
	logic [31:0] diff;
	logic        peak;
	logic [31:0] dur;
	logic [31:0] elapsed;
	logic        idle_push;
	logic        m_pos;
	logic        out_free;
	logic [17:0] hr18, lo18, hi18;
	logic        gate_ok;
	logic        cfg_wr;

	ppg_prd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q  <= TPM_RESET;
			idle_q <= IDLE_RESET;
			gate_q <= GATE_RESET;
		end else if (cfg_wr) begin
			case (paddr)
				ADDR_TICKS_PER_MINUTE: tpm_q  <= pwdata[15:0];
				ADDR_IDLE_TICKS_LIMIT: idle_q <= pwdata[15:0];
				ADDR_RATE_GATE:        gate_q <= pwdata[7:0];
				default:               ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr)
			ADDR_TICKS_PER_MINUTE: prdata = {16'd0, tpm_q};
			ADDR_IDLE_TICKS_LIMIT: prdata = {16'd0, idle_q};
			ADDR_RATE_GATE:        prdata = {24'd0, gate_q};
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------

	// Scaling by shifts, then the two halves of the band-pass recursion.
	assign x_val = {20'd0, 12'(({1'b0, raw_q} >> 3) + (raw_q >> 5) + (raw_q >> 6))};
	assign y_val = acc_q + fh0_q + 32'($signed(fh0_q) >>> 1) + 32'($signed(fh0_q) >>> 2)
		- 32'($signed(fh0_q) >>> 4);

	// Rounded mean: floor division of the biased sum, done on the one's
	// complement of negative sums so that the core division is unsigned.
	assign sel_avg      = (state_q == ST_AVG_GO);
	assign mean_use_div = sel_avg ? !AVG_POW2 : !HIST_POW2;
	assign mean_s       = sel_avg ? (avg_sum_q + AVG_HALF)
		: ((state_q == ST_THR_GO) ? swg_sum_q : ivl_sum_q) + HIST_HALF;
	assign mean_u       = mean_s[31] ? ~mean_s : mean_s;
	assign mean_pow2    = sel_avg ? (mean_u >> AVG_LOG) : (mean_u >> HIST_LOG);
	assign mean_q       = mean_s[31] ? ~mean_pow2 : mean_pow2;

	// Direction of the filtered value against the previous one.
	assign f_rise = $signed(f_q) > $signed(prev_f_q);
	assign f_fall = $signed(f_q) < $signed(prev_f_q);

	// Peak decision against half the mean swing (res_q holds that mean).
	assign diff      = rmax_q - rmin_q;
	assign peak      = $signed({diff[31], diff, 1'b0}) > $signed({{2{res_q[31]}}, res_q});
	assign dur       = (tick_q > lpt_q) ? (tick_q - lpt_q) : (tick_q - lpt_q - 32'd1);
	assign elapsed   = tick_q - lpt_q;
	assign idle_push = !peak && (elapsed > {16'd0, idle_q});

	// Positive check of the interval mean, and the rate gate on the divider quotient.
	assign m_pos   = !res_q[31] && (res_q != 32'd0);
	assign hr18    = {2'b00, res_q[15:0]};
	assign lo18    = {2'b00, held_q} - {10'd0, gate_q};
	assign hi18    = {2'b00, held_q} + {10'd0, gate_q};
	assign gate_ok = ($signed(hr18) > $signed(lo18)) && ($signed(hr18) < $signed(hi18))
		&& (res_q[31:16] == 16'd0);

	assign out_free = !m_tvalid_q || m_tready;

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_FILT1;
			ST_FILT1:    state_d = ST_FILT2;
			ST_FILT2:    state_d = ST_AVG_PUSH;
			ST_AVG_PUSH: state_d = ST_AVG_GO;
			ST_AVG_GO:   state_d = mean_use_div ? ST_DIV_WAIT : ST_THR_GO;
			ST_THR_GO:   state_d = mean_use_div ? ST_DIV_WAIT : ST_TURN;
			ST_TURN:     state_d = ST_PEAK;
			ST_PEAK:     state_d = ST_INT_GO;
			ST_INT_GO:   state_d = mean_use_div ? ST_DIV_WAIT : ST_RATE_GO;
			ST_RATE_GO:  state_d = m_pos ? ST_DIV_WAIT : ST_DONE;
			ST_DIV_WAIT: if (div_rsp.done) state_d = ret_q;
			ST_GATE:     state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs (handshake and divider requests)
	// ------------------------------------------------------------------
	always_comb begin
		s_tready         = (state_q == ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = mean_u;
		div_req.divisor  = sel_avg ? 32'(AVERAGE_TAPS) : 32'(HISTORY_DEPTH);
		case (state_q)
			ST_AVG_GO, ST_THR_GO, ST_INT_GO: begin
				div_req.start = mean_use_div;
			end
			ST_RATE_GO: begin
				div_req.start    = m_pos;
				div_req.dividend = {16'd0, tpm_q};
				div_req.divisor  = res_q;
			end
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Filter, detection and rate state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh0_q      <= '0;
			sh1_q      <= '0;
			fh0_q      <= '0;
			fh1_q      <= '0;
			for (int i = 0; i < AVERAGE_TAPS; i++) win_q[i] <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				ivl_q[i] <= '0;
				swg_q[i] <= '0;
			end
			avg_sum_q  <= '0;
			ivl_sum_q  <= '0;
			swg_sum_q  <= '0;
			prev_f_q   <= '0;
			prev_dir_q <= DIR_NONE;
			rmax_q     <= RMAX_RESET;
			rmin_q     <= RMIN_RESET;
			lpt_q      <= '0;
			held_q     <= HELD_RESET;
			ret_q      <= ST_IDLE;
			acc_q      <= '0;
			res_q      <= '0;
			f_q        <= '0;
			neg_q      <= 1'b0;
			peak_q     <= 1'b0;
		end else begin
			case (state_q)
				// Input half of the recursion and the scaled-sample history.
				ST_FILT1: begin
					acc_q <= x_val - sh1_q - 32'($signed(fh1_q) >>> 1)
						- 32'($signed(fh1_q) >>> 2) + 32'($signed(fh1_q) >>> 5);
					sh1_q <= sh0_q;
					sh0_q <= x_val;
				end
				// Feedback half and the filter history.
				ST_FILT2: begin
					fh1_q <= fh0_q;
					fh0_q <= y_val;
				end
				// Slide the averaging window, keeping its sum current.
				ST_AVG_PUSH: begin
					for (int i = 0; i < AVERAGE_TAPS - 1; i++) win_q[i] <= win_q[i + 1];
					win_q[AVERAGE_TAPS-1] <= fh0_q;
					avg_sum_q <= avg_sum_q - win_q[0] + fh0_q;
				end
				// Window mean, then swing mean.
				ST_AVG_GO: begin
					res_q <= mean_q;
					neg_q <= mean_s[31];
					ret_q <= ST_THR_GO;
				end
				ST_THR_GO: begin
					f_q   <= res_q;
					res_q <= mean_q;
					neg_q <= mean_s[31];
					ret_q <= ST_TURN;
				end
				// Record turning points and the new direction.
				ST_TURN: begin
					if (f_fall && prev_dir_q == DIR_RISE
							&& $signed(prev_f_q) > $signed(rmax_q)) begin
						rmax_q <= f_q;
					end
					if (f_rise && prev_dir_q == DIR_FALL
							&& $signed(prev_f_q) < $signed(rmin_q)) begin
						rmin_q <= f_q;
					end
					if (f_rise) begin
						prev_dir_q <= DIR_RISE;
					end else if (f_fall) begin
						prev_dir_q <= DIR_FALL;
					end
					prev_f_q <= f_q;
				end
				// Peak declaration, the history pushes it causes, and the idle swing push.
				ST_PEAK: begin
					peak_q <= peak;
					if (peak) begin
						for (int i = 0; i < HISTORY_DEPTH - 1; i++) ivl_q[i] <= ivl_q[i + 1];
						ivl_q[HISTORY_DEPTH-1] <= dur;
						ivl_sum_q <= ivl_sum_q - ivl_q[0] + dur;
						rmax_q    <= RMAX_RESET;
						rmin_q    <= RMIN_RESET;
						lpt_q     <= tick_q;
					end
					if (peak || idle_push) begin
						for (int i = 0; i < HISTORY_DEPTH - 1; i++) swg_q[i] <= swg_q[i + 1];
						swg_q[HISTORY_DEPTH-1] <= diff;
						swg_sum_q <= swg_sum_q - swg_q[0] + diff;
					end
				end
				// Interval mean.
				ST_INT_GO: begin
					res_q <= mean_q;
					neg_q <= mean_s[31];
					ret_q <= ST_RATE_GO;
				end
				// Rate division; the quotient needs no sign fix.
				ST_RATE_GO: begin
					neg_q <= 1'b0;
					ret_q <= ST_GATE;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						res_q <= neg_q ? ~div_rsp.quotient : div_rsp.quotient;
					end
				end
				// Accept the new rate only inside the gate around the held one.
				ST_GATE: begin
					if (gate_ok) begin
						held_q <= res_q[15:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Sample capture on an accepted request.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_q  <= s_tdata[11:0];
			tick_q <= s_tdata[43:12];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_f_q    <= f_q;
			out_rate_q <= held_q;
			out_peak_q <= peak_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_rate_q, out_f_q};
	assign m_tuser  = out_peak_q;

endmodule

// ===== src/ppg_prd_chk.sv =====
// ============================================================================
// ppg_prd_chk
// Port-level checker for the pulse rate detector, bound to the top level.
// ============================================================================
module ppg_prd_chk
	import ppg_prd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// After taking a sample the block is busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample taken while still busy");

	// The block only leaves idle by taking a sample.
	a_busy_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("block went busy without a sample");

	// A new result is posted in the same step that returns the block to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result posted while block not idle");

endmodule

bind ppg_pulse_rate_detector_top ppg_prd_chk u_ppg_prd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the optical pulse rate detector. Sample requests
// are streamed in from a queue, each accepted request is run through a
// bit-true predictor of the filter, peak and rate logic, and every result
// on the output stream is compared field by field with the oldest
// prediction. Phases change the registers and the idle and stall patterns.
// ============================================================================
module testbench;
	import ppg_prd_pkg::*;

	localparam int AVG_TAPS         = 8;
	localparam int HIST_DEPTH       = 4;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 60;
	localparam int PHASE_SAMPLES    = 160;
	localparam int PHASE_COUNT      = 6;

	typedef struct packed {
		logic [31:0] filtered;
		logic [15:0] rate;
		logic        peak;
	} pulse_result_t;

	typedef struct packed {
		logic [11:0] raw;
		logic [31:0] tick;
	} sample_t;

	typedef enum logic [1:0] {
		GAP_NONE,
		GAP_SENDER,
		GAP_RECEIVER,
		GAP_BOTH
	} gap_mode_t;

	// Block ports.
	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [3:0]           paddr    = '0;
	logic [31:0]          pwdata   = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Stimulus and scoreboard.
	sample_t       pending_samples[$];
	pulse_result_t expected_results[$];
	gap_mode_t     gap_mode        = GAP_NONE;
	logic          sample_taken    = 1'b0;
	logic [31:0]   sample_clock    = '0;
	int unsigned   error_count     = 0;
	int unsigned   results_checked = 0;
	int unsigned   stall_cycles    = 0;
	int unsigned   hold_left       = 0;
	logic          long_hold_done  = 1'b0;

	// Predictor copy of the registers and of the detector state.
	logic [15:0] tpm_model  = TPM_RESET;
	logic [15:0] idle_model = IDLE_RESET;
	logic [7:0]  gate_model = GATE_RESET;
	logic [31:0] scaled_hist[2];
	logic [31:0] filt_hist[2];
	logic [31:0] avg_window[$];
	logic [31:0] beat_intervals[$];
	logic [31:0] swing_hist[$];
	logic [31:0] prev_filtered;
	logic [31:0] run_max;
	logic [31:0] run_min;
	logic [31:0] last_peak_tick;
	dir_t        prev_dir;
	logic [15:0] held_rate_model;

	// Corner requests: converter extremes, alternating bit patterns, tick
	// wrap-around, repeated and backward ticks, and huge tick jumps that
	// make the mean interval negative.
	sample_t corner_samples[24] = '{
		{12'd4095, 32'd0}, {12'd4095, 32'd1}, {12'd0, 32'd2}, {12'd0, 32'd3},
		{12'd4095, 32'd4}, {12'd4095, 32'd5}, {12'd0, 32'd6}, {12'd0, 32'd7},
		{12'd4095, 32'd8}, {12'd4095, 32'd9}, {12'd0, 32'd10}, {12'd0, 32'd11},
		{12'd4095, 32'h7000_0000}, {12'd0, 32'h7000_0001},
		{12'd4095, 32'hE000_0000}, {12'd0, 32'hE000_0001},
		{12'd2730, 32'hFFFF_FFFF}, {12'd1365, 32'h0000_0005},
		{12'd4095, 32'h0000_0005}, {12'd0, 32'h0000_0003},
		{12'd4095, 32'h5555_5555}, {12'd0, 32'hAAAA_AAAA},
		{12'd4095, 32'h8000_0000}, {12'd0, 32'hFFFF_FFFE}
	};

	ppg_pulse_rate_detector_top #(
		.AVERAGE_TAPS (AVG_TAPS),
		.HISTORY_DEPTH(HIST_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Arithmetic shift right of a 32-bit two's complement word.
	function automatic logic [31:0] sra(input logic [31:0] v, input int sh);
		return $signed(v) >>> sh;
	endfunction

	// Wrapping 32-bit sum of a history.
	function automatic logic [31:0] wrap_total(input logic [31:0] vals[$]);
		logic [31:0] acc;
		acc = '0;
		foreach (vals[i])
			acc = acc + vals[i];
		return acc;
	endfunction

	// Rounded mean: add half the count, then divide rounding toward minus infinity.
	function automatic logic [31:0] floor_mean(input logic [31:0] total, input int n);
		logic [31:0] biased;
		longint      v;
		longint      q;
		biased = total + 32'(n / 2);
		v = longint'($signed(biased));
		q = v / n;
		if (v % n != 0 && v < 0)
			q = q - 1;
		return q[31:0];
	endfunction

	// Advances the detector state by one sample and returns its result.
	function automatic pulse_result_t predict_pulse(input logic [11:0] raw,
			input logic [31:0] tick);
		logic [31:0]   x, y, y1, y2, f, thr, diff, mean, dur;
		dir_t          dir;
		logic          peak;
		longint        m, hr, held, gate;
		pulse_result_t r;

		// Shift scaling and the band-pass section.
		x = (32'(raw) >> 3) + (32'(raw) >> 5) + (32'(raw) >> 6);
		y1 = filt_hist[0];
		y2 = filt_hist[1];
		y = (x - scaled_hist[1]) - (sra(y2, 1) + sra(y2, 2) - sra(y2, 5))
			+ (y1 + sra(y1, 1) + sra(y1, 2) - sra(y1, 4));
		scaled_hist[1] = scaled_hist[0];
		scaled_hist[0] = x;
		filt_hist[1] = filt_hist[0];
		filt_hist[0] = y;

		// Moving average.
		void'(avg_window.pop_front());
		avg_window.push_back(y);
		f = floor_mean(wrap_total(avg_window), AVG_TAPS);

		// Direction and turning points.
		thr = floor_mean(wrap_total(swing_hist), HIST_DEPTH);
		if ($signed(f) > $signed(prev_filtered))
			dir = DIR_RISE;
		else if ($signed(f) < $signed(prev_filtered))
			dir = DIR_FALL;
		else
			dir = DIR_NONE;
		if (dir == DIR_FALL && prev_dir == DIR_RISE && $signed(prev_filtered) > $signed(run_max))
			run_max = f;
		if (dir == DIR_RISE && prev_dir == DIR_FALL && $signed(prev_filtered) < $signed(run_min))
			run_min = f;
		diff = run_max - run_min;

		// Peak: the swing beats half the mean of recent swings.
		peak = (2 * longint'($signed(diff))) > longint'($signed(thr));
		if (peak) begin
			// A tick at or behind the last peak counts one less, modulo 2^32.
			if (tick > last_peak_tick)
				dur = tick - last_peak_tick;
			else
				dur = tick - last_peak_tick - 32'd1;
			void'(beat_intervals.pop_front());
			beat_intervals.push_back(dur);
			void'(swing_hist.pop_front());
			swing_hist.push_back(diff);
			run_max = RMAX_RESET;
			run_min = RMIN_RESET;
			last_peak_tick = tick;
		end

		// Long without a peak, the swing history keeps refreshing.
		if ((tick - last_peak_tick) > 32'(idle_model)) begin
			void'(swing_hist.pop_front());
			swing_hist.push_back(diff);
		end
		prev_filtered = f;
		if (dir != DIR_NONE)
			prev_dir = dir;

		// Rate; a zero or negative mean interval keeps the held rate.
		mean = floor_mean(wrap_total(beat_intervals), HIST_DEPTH);
		m = longint'($signed(mean));
		if (m > 0) begin
			hr = longint'(tpm_model) / m;
			held = longint'(held_rate_model);
			gate = longint'(gate_model);
			if (hr > held - gate && hr < held + gate)
				held_rate_model = hr[15:0];
		end

		r.filtered = f;
		r.rate = held_rate_model;
		r.peak = peak;
		return r;
	endfunction

	// Sample driver: holds a request until it is taken, then offers the next.
	always @(negedge clk) begin : sample_driver
		logic gap;
		gap = (gap_mode == GAP_SENDER && $urandom_range(0, 99) < 45)
			|| (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 35);
		if (!s_tvalid || sample_taken) begin
			if (pending_samples.size() != 0 && !gap) begin
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, pending_samples[0].tick, pending_samples[0].raw};
				void'(pending_samples.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result ready: random stalls, plus one long hold-off in the receiver phase.
	always @(negedge clk) begin : result_ready_driver
		logic stall;
		stall = (gap_mode == GAP_RECEIVER && $urandom_range(0, 99) < 45)
			|| (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 35);
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (gap_mode == GAP_RECEIVER && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !stall;
		end
	end

	// Monitor: predicts on each taken sample, checks each taken result.
	always @(posedge clk) begin : stream_monitor
		pulse_result_t want;
		sample_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			expected_results.push_back(predict_pulse(s_tdata[11:0], s_tdata[43:12]));
		if (m_tvalid && m_tready) begin
			results_checked = results_checked + 1;
			if (expected_results.size() == 0) begin
				error_count = error_count + 1;
				$display("%0t: unexpected result: filtered_value %0d heart_rate %0d peak_found %0b",
					$time, $signed(m_tdata[31:0]), m_tdata[47:32], m_tuser);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.filtered) begin
					error_count = error_count + 1;
					$display("%0t: filtered_value expected %0d, got %0d", $time,
						$signed(want.filtered), $signed(m_tdata[31:0]));
				end
				if (m_tdata[47:32] !== want.rate) begin
					error_count = error_count + 1;
					$display("%0t: heart_rate expected %0d, got %0d", $time,
						want.rate, m_tdata[47:32]);
				end
				if (m_tuser !== want.peak) begin
					error_count = error_count + 1;
					$display("%0t: peak_found expected %0b, got %0b", $time,
						want.peak, m_tuser);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Register write through the APB port, mirrored into the predictor.
	task automatic write_register(input logic [3:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (addr)
			ADDR_TICKS_PER_MINUTE: tpm_model = value[15:0];
			ADDR_IDLE_TICKS_LIMIT: idle_model = value[15:0];
			ADDR_RATE_GATE:        gate_model = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every queued request went in and every result came out.
	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Triangle-shaped pulse trains with random period, amplitude, offset and
	// tick step; about one train in ten is pure noise with random tick jumps.
	task automatic add_pulse_trains(input int count);
		int   added, period, amp, base, tick_step, len, level, ph;
		logic noisy;
		added = 0;
		while (added < count) begin
			len = $urandom_range(40, 120);
			noisy = ($urandom_range(0, 9) == 0);
			period = $urandom_range(16, 60);
			amp = $urandom_range(40, 2047);
			base = $urandom_range(0, 4095 - amp);
			tick_step = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0)
				sample_clock = $urandom;
			for (int i = 0; i < len; i++) begin
				ph = i % period;
				level = base + ((ph < period / 2) ? ph : period - ph) * 2 * amp / period;
				level = level + $urandom_range(0, 15);
				if (level > 4095)
					level = 4095;
				if (noisy) begin
					level = $urandom_range(0, 4095);
					if ($urandom_range(0, 7) == 0)
						sample_clock = sample_clock + $urandom;
					else
						sample_clock = sample_clock + $urandom_range(0, 20);
				end else begin
					sample_clock = sample_clock + tick_step;
				end
				pending_samples.push_back('{raw: level[11:0], tick: sample_clock});
			end
			added = added + len;
		end
	endtask

	// Main sequence: reset, corner requests, then register and idling phases.
	initial begin : stimulus
		logic [15:0] tpm_set[PHASE_COUNT]   = '{16'd3000, 16'd65535, 16'd1, 16'd3000, 16'd0, 16'd3600};
		logic [15:0] idle_set[PHASE_COUNT]  = '{16'd200, 16'd0, 16'd65535, 16'd50, 16'd0, 16'd300};
		logic [7:0]  gate_set[PHASE_COUNT]  = '{8'd15, 8'd255, 8'd0, 8'd60, 8'd0, 8'd20};
		gap_mode_t   modes[PHASE_COUNT]     = '{GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH,
			GAP_NONE, GAP_BOTH};

		for (int i = 0; i < 2; i++) begin
			scaled_hist[i] = '0;
			filt_hist[i] = '0;
		end
		for (int i = 0; i < AVG_TAPS; i++)
			avg_window.push_back('0);
		for (int i = 0; i < HIST_DEPTH; i++) begin
			beat_intervals.push_back('0);
			swing_hist.push_back('0);
		end
		prev_filtered = '0;
		prev_dir = DIR_NONE;
		run_max = RMAX_RESET;
		run_min = RMIN_RESET;
		last_peak_tick = '0;
		held_rate_model = HELD_RESET;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The corner requests run with the reset register values.
		foreach (corner_samples[i])
			pending_samples.push_back(corner_samples[i]);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p != 0) begin
				// The sender pauses here until every result is back.
				wait_drained();
				repeat (SETTLE_CYCLES) @(negedge clk);
				if (p == 4) begin
					tpm_set[p] = 16'($urandom_range(1, 65535));
					idle_set[p] = 16'($urandom_range(0, 65535));
					gate_set[p] = 8'($urandom_range(0, 255));
				end
				write_register(ADDR_TICKS_PER_MINUTE, 32'(tpm_set[p]));
				write_register(ADDR_IDLE_TICKS_LIMIT, 32'(idle_set[p]));
				write_register(ADDR_RATE_GATE, 32'(gate_set[p]));
				@(posedge clk);
			end
			gap_mode = modes[p];
			add_pulse_trains(PHASE_SAMPLES);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/ppg_prd_pkg.sv
src/ppg_prd_div.sv
src/ppg_pulse_rate_detector_top.sv
src/ppg_prd_chk.sv
verif/testbench.sv
